// ===== hdl/sorted_region_table_macros.svh =====
// ----------------------------------------------------------------------------
// sorted_region_table_macros
// Assertion macros used by the sorted region table datapath.
// ----------------------------------------------------------------------------
`ifndef SORTED_REGION_TABLE_MACROS_SVH
`define SORTED_REGION_TABLE_MACROS_SVH

// same-cycle implication
`define SRT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sorted region table check failed");

// next-cycle implication
`define SRT_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sorted region table check failed");

`endif

// ===== hdl/srt_pkg.sv =====
// ----------------------------------------------------------------------------
// srt_pkg
// Codes and controller/datapath interface types of the sorted region table.
// ----------------------------------------------------------------------------
package srt_pkg;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_LOOKUP = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;

   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_OVERLAP = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;
   localparam logic [1:0] ST_MISS    = 2'd3;

   localparam logic [1:0] RD_IDX   = 2'd0;
   localparam logic [1:0] RD_LAST  = 2'd1;
   localparam logic [1:0] RD_SHIFT = 2'd2;

   localparam logic [2:0] WR_NONE  = 3'd0;
   localparam logic [2:0] WR_SHIFT = 3'd1;
   localparam logic [2:0] WR_NEW   = 3'd2;
   localparam logic [2:0] WR_LEFT  = 3'd3;
   localparam logic [2:0] WR_RIGHT = 3'd4;
   localparam logic [2:0] WR_SPLIT = 3'd5;

   typedef struct packed {
      logic       load;
      logic       rd_en;
      logic [1:0] rd_sel;
      logic [2:0] wr_sel;
      logic       sh_open;
      logic       ent_ld;
      logic       i_inc;
      logic       i_inc2;
      logic       prev_ld;
      logic       back_ld;
      logic       k_open;
      logic       k_close;
      logic       k_step;
      logic       pos_zero;
      logic       pos_cnt;
      logic       pos_i;
      logic       pos_next;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       stat_ld;
      logic [1:0] stat;
      logic       hit_ld;
      logic       out_ld;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       cnt_zero;
      logic       cnt_full;
      logic       i_end;
      logic       i_first;
      logic       contains;
      logic       front_fit;
      logic       back_fit;
      logic       gap_fit;
      logic       meet;
      logic       left;
      logic       right;
      logic       sh_more;
      logic       out_free;
   } sts_type;

endpackage

// ===== hdl/srt_ram.sv =====
// ----------------------------------------------------------------------------
// srt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module srt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/srt_ctrl.sv =====
// ----------------------------------------------------------------------------
// srt_ctrl
// Sequencer for insert, lookup and remove-range walks and entry shifts.
// ----------------------------------------------------------------------------
module srt_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  srt_pkg::sts_type sts,
   output srt_pkg::cmd_type cmd
);

   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_GO      = 5'd1;
   localparam logic [4:0] S_LK_RD   = 5'd2;
   localparam logic [4:0] S_LK_CHK  = 5'd3;
   localparam logic [4:0] S_IN_RDL  = 5'd4;
   localparam logic [4:0] S_IN_CHKL = 5'd5;
   localparam logic [4:0] S_IN_RD   = 5'd6;
   localparam logic [4:0] S_IN_CHK  = 5'd7;
   localparam logic [4:0] S_IN_FIT  = 5'd8;
   localparam logic [4:0] S_IN_WR   = 5'd9;
   localparam logic [4:0] S_RM_RD   = 5'd10;
   localparam logic [4:0] S_RM_CHK  = 5'd11;
   localparam logic [4:0] S_SP_WR1  = 5'd12;
   localparam logic [4:0] S_SP_WR0  = 5'd13;
   localparam logic [4:0] S_SH_RD   = 5'd14;
   localparam logic [4:0] S_SH_WR   = 5'd15;
   localparam logic [4:0] S_FIN     = 5'd16;

   logic [4:0] state_ff, state_in;
   logic       mode_ff, mode_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      mode_in  = mode_ff;
      cmd.sh_open = mode_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_GO;
            end
         end
         S_GO: begin
            unique case (sts.op)
               srt_pkg::OP_LOOKUP: state_in = S_LK_RD;
               srt_pkg::OP_REMOVE: state_in = S_RM_RD;
               srt_pkg::OP_INSERT: begin
                  if (sts.cnt_zero) begin
                     cmd.pos_zero = 1'b1;
                     state_in     = S_IN_FIT;
                  end else begin
                     state_in = S_IN_RDL;
                  end
               end
               default: state_in = S_FIN;
            endcase
         end
         S_LK_RD: begin
            if (sts.i_end) begin
               cmd.stat_ld = 1'b1;
               cmd.stat    = srt_pkg::ST_MISS;
               state_in    = S_FIN;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = srt_pkg::RD_IDX;
               state_in   = S_LK_CHK;
            end
         end
         S_LK_CHK: begin
            cmd.ent_ld = 1'b1;
            if (sts.contains) begin
               cmd.hit_ld = 1'b1;
               state_in   = S_FIN;
            end else begin
               cmd.i_inc = 1'b1;
               state_in  = S_LK_RD;
            end
         end
         S_IN_RDL: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = srt_pkg::RD_LAST;
            state_in   = S_IN_CHKL;
         end
         S_IN_CHKL: begin
            cmd.ent_ld  = 1'b1;
            cmd.back_ld = 1'b1;
            state_in    = S_IN_RD;
         end
         S_IN_RD: begin
            if (sts.i_end) begin
               cmd.stat_ld = 1'b1;
               cmd.stat    = srt_pkg::ST_OVERLAP;
               state_in    = S_FIN;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = srt_pkg::RD_IDX;
               state_in   = S_IN_CHK;
            end
         end
         S_IN_CHK: begin
            cmd.ent_ld = 1'b1;
            priority if (sts.i_first && sts.front_fit) begin
               cmd.pos_zero = 1'b1;
               state_in     = S_IN_FIT;
            end else if (sts.i_first && sts.back_fit) begin
               cmd.pos_cnt = 1'b1;
               state_in    = S_IN_FIT;
            end else if (!sts.i_first && sts.gap_fit) begin
               cmd.pos_i = 1'b1;
               state_in  = S_IN_FIT;
            end else begin
               cmd.prev_ld = 1'b1;
               cmd.i_inc   = 1'b1;
               state_in    = S_IN_RD;
            end
         end
         S_IN_FIT: begin
            if (sts.cnt_full) begin
               cmd.stat_ld = 1'b1;
               cmd.stat    = srt_pkg::ST_FULL;
               state_in    = S_FIN;
            end else begin
               cmd.k_open = 1'b1;
               mode_in    = 1'b1;
               state_in   = S_SH_RD;
            end
         end
         S_IN_WR: begin
            cmd.wr_sel  = srt_pkg::WR_NEW;
            cmd.cnt_inc = 1'b1;
            state_in    = S_FIN;
         end
         S_RM_RD: begin
            if (sts.i_end) begin
               state_in = S_FIN;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = srt_pkg::RD_IDX;
               state_in   = S_RM_CHK;
            end
         end
         S_RM_CHK: begin
            cmd.ent_ld = 1'b1;
            priority if (!sts.meet) begin
               cmd.i_inc = 1'b1;
               state_in  = S_RM_RD;
            end else if (!sts.left && !sts.right) begin
               cmd.k_close = 1'b1;
               mode_in     = 1'b0;
               state_in    = S_SH_RD;
            end else if (sts.left && sts.right) begin
               if (sts.cnt_full) begin
                  cmd.stat_ld = 1'b1;
                  cmd.stat    = srt_pkg::ST_FULL;
                  state_in    = S_FIN;
               end else begin
                  cmd.pos_next = 1'b1;
                  cmd.k_open   = 1'b1;
                  mode_in      = 1'b1;
                  state_in     = S_SH_RD;
               end
            end else if (sts.left) begin
               cmd.wr_sel = srt_pkg::WR_LEFT;
               cmd.i_inc  = 1'b1;
               state_in   = S_RM_RD;
            end else begin
               cmd.wr_sel = srt_pkg::WR_RIGHT;
               cmd.i_inc  = 1'b1;
               state_in   = S_RM_RD;
            end
         end
         S_SP_WR1: begin
            cmd.wr_sel = srt_pkg::WR_SPLIT;
            state_in   = S_SP_WR0;
         end
         S_SP_WR0: begin
            cmd.wr_sel  = srt_pkg::WR_LEFT;
            cmd.cnt_inc = 1'b1;
            cmd.i_inc2  = 1'b1;
            state_in    = S_RM_RD;
         end
         S_SH_RD: begin
            priority if (sts.sh_more) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = srt_pkg::RD_SHIFT;
               state_in   = S_SH_WR;
            end else if (sts.op == srt_pkg::OP_INSERT) begin
               state_in = S_IN_WR;
            end else if (mode_ff) begin
               state_in = S_SP_WR1;
            end else begin
               cmd.cnt_dec = 1'b1;
               state_in    = S_RM_RD;
            end
         end
         S_SH_WR: begin
            cmd.wr_sel = srt_pkg::WR_SHIFT;
            cmd.k_step = 1'b1;
            state_in   = S_SH_RD;
         end
         S_FIN: begin
            if (sts.out_free) begin
               cmd.out_ld = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mode_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

// ===== hdl/srt_dpath.sv =====
// ----------------------------------------------------------------------------
// srt_dpath
// Request registers, table RAM, walk indexes, compares and result word.
// ----------------------------------------------------------------------------
`include "sorted_region_table_macros.svh"

module srt_dpath #(
   parameter int TABLE_DEPTH  = 16,
   parameter int ADDRESS_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  srt_pkg::cmd_type cmd,
   output srt_pkg::sts_type sts,
   input  logic [1:0]       req_operation,
   input  logic [31:0]      req_range_start,
   input  logic [31:0]      req_range_end,
   input  logic [31:0]      req_base_offset,
   input  logic [31:0]      req_query_address,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [31:0]      rsp_found_start,
   output logic [31:0]      rsp_found_end,
   output logic [31:0]      rsp_found_offset
);

   localparam int AW = (ADDRESS_BITS < 32) ? ADDRESS_BITS : 32;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int EW = 2 * AW + 32;
   localparam logic [CW-1:0] ONE  = CW'(1);
   localparam logic [CW-1:0] FULL = CW'(TABLE_DEPTH);

   logic [1:0]    op_ff, op_in;
   logic [AW-1:0] s_ff, s_in, e_ff, e_in, q_ff, q_in, prev_ff, prev_in;
   logic [31:0]   off_ff, off_in;
   logic [CW-1:0] i_ff, i_in, k_ff, k_in, pos_ff, pos_in, cnt_ff, cnt_in;
   logic          back_ff, back_in;
   logic [AW-1:0] ms_ff, ms_in, me_ff, me_in;
   logic [31:0]   mo_ff, mo_in;
   logic [1:0]    stat_ff, stat_in;
   logic [31:0]   fs_ff, fs_in, fe_ff, fe_in, fo_ff, fo_in;
   logic          rv_ff, rv_in;
   logic [1:0]    rst_ff, rst_in;
   logic [31:0]   rs_ff, rs_in, re_ff, re_in, ro_ff, ro_in;

   logic [EW-1:0] rd_data, wr_data;
   logic [IW-1:0] rd_addr, wr_addr;
   logic [CW-1:0] rd_idx, wr_idx;
   logic          wr_en;
   logic [AW-1:0] cur_s, cur_e;
   logic [31:0]   cur_o, trim_o;

   assign cur_s  = cmd.ent_ld ? rd_data[EW-1 -: AW] : ms_ff;
   assign cur_e  = cmd.ent_ld ? rd_data[EW-AW-1 -: AW] : me_ff;
   assign cur_o  = cmd.ent_ld ? rd_data[31:0] : mo_ff;
   assign trim_o = cur_o + 32'(e_ff - cur_s);

   always_comb begin
      unique case (cmd.rd_sel)
         srt_pkg::RD_LAST:  rd_idx = cnt_ff - ONE;
         srt_pkg::RD_SHIFT: rd_idx = cmd.sh_open ? (k_ff - ONE) : (k_ff + ONE);
         default:           rd_idx = i_ff;
      endcase
      wr_en   = 1'b1;
      wr_idx  = i_ff;
      wr_data = {cur_s, s_ff, cur_o};
      unique case (cmd.wr_sel)
         srt_pkg::WR_SHIFT: begin
            wr_idx  = k_ff;
            wr_data = rd_data;
         end
         srt_pkg::WR_NEW: begin
            wr_idx  = pos_ff;
            wr_data = {s_ff, e_ff, off_ff};
         end
         srt_pkg::WR_LEFT: begin
            wr_idx  = i_ff;
            wr_data = {cur_s, s_ff, cur_o};
         end
         srt_pkg::WR_RIGHT: begin
            wr_idx  = i_ff;
            wr_data = {e_ff, cur_e, trim_o};
         end
         srt_pkg::WR_SPLIT: begin
            wr_idx  = pos_ff;
            wr_data = {e_ff, cur_e, trim_o};
         end
         default: wr_en = 1'b0;
      endcase
   end

   assign rd_addr = rd_idx[IW-1:0];
   assign wr_addr = wr_idx[IW-1:0];

   srt_ram #(
      .WIDTH(EW),
      .DEPTH(TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      op_in   = op_ff;
      s_in    = s_ff;
      e_in    = e_ff;
      q_in    = q_ff;
      off_in  = off_ff;
      i_in    = i_ff;
      k_in    = k_ff;
      pos_in  = pos_ff;
      cnt_in  = cnt_ff;
      prev_in = prev_ff;
      back_in = back_ff;
      ms_in   = ms_ff;
      me_in   = me_ff;
      mo_in   = mo_ff;
      stat_in = stat_ff;
      fs_in   = fs_ff;
      fe_in   = fe_ff;
      fo_in   = fo_ff;
      rv_in   = rv_ff;
      rst_in  = rst_ff;
      rs_in   = rs_ff;
      re_in   = re_ff;
      ro_in   = ro_ff;
      if (cmd.load) begin
         op_in   = req_operation;
         s_in    = req_range_start[AW-1:0];
         e_in    = req_range_end[AW-1:0];
         q_in    = req_query_address[AW-1:0];
         off_in  = req_base_offset;
         i_in    = '0;
         stat_in = srt_pkg::ST_DONE;
         fs_in   = '0;
         fe_in   = '0;
         fo_in   = '0;
      end
      if (cmd.ent_ld) begin
         ms_in = cur_s;
         me_in = cur_e;
         mo_in = cur_o;
      end
      if (cmd.i_inc) i_in = i_ff + ONE;
      if (cmd.i_inc2) i_in = i_ff + CW'(2);
      if (cmd.prev_ld) prev_in = cur_e;
      if (cmd.back_ld) back_in = (s_ff >= cur_e);
      if (cmd.k_open) k_in = cnt_ff;
      if (cmd.k_close) k_in = i_ff;
      if (cmd.k_step) k_in = cmd.sh_open ? (k_ff - ONE) : (k_ff + ONE);
      if (cmd.pos_zero) pos_in = '0;
      if (cmd.pos_cnt) pos_in = cnt_ff;
      if (cmd.pos_i) pos_in = i_ff;
      if (cmd.pos_next) pos_in = i_ff + ONE;
      if (cmd.cnt_inc) cnt_in = cnt_ff + ONE;
      if (cmd.cnt_dec) cnt_in = cnt_ff - ONE;
      if (cmd.stat_ld) stat_in = cmd.stat;
      if (cmd.hit_ld) begin
         fs_in = 32'(cur_s);
         fe_in = 32'(cur_e);
         fo_in = cur_o;
      end
      if (rv_ff && !rsp_stall) rv_in = 1'b0;
      if (cmd.out_ld) begin
         rv_in  = 1'b1;
         rst_in = stat_ff;
         rs_in  = fs_ff;
         re_in  = fe_ff;
         ro_in  = fo_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rv_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rv_ff  <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      s_ff    <= s_in;
      e_ff    <= e_in;
      q_ff    <= q_in;
      off_ff  <= off_in;
      i_ff    <= i_in;
      k_ff    <= k_in;
      pos_ff  <= pos_in;
      prev_ff <= prev_in;
      back_ff <= back_in;
      ms_ff   <= ms_in;
      me_ff   <= me_in;
      mo_ff   <= mo_in;
      stat_ff <= stat_in;
      fs_ff   <= fs_in;
      fe_ff   <= fe_in;
      fo_ff   <= fo_in;
      rst_ff  <= rst_in;
      rs_ff   <= rs_in;
      re_ff   <= re_in;
      ro_ff   <= ro_in;
   end

   always_comb begin
      sts.op        = op_ff;
      sts.cnt_zero  = (cnt_ff == '0);
      sts.cnt_full  = (cnt_ff >= FULL);
      sts.i_end     = (i_ff >= cnt_ff);
      sts.i_first   = (i_ff == '0);
      sts.contains  = (cur_s <= q_ff) && (q_ff < cur_e);
      sts.front_fit = (e_ff <= cur_s);
      sts.back_fit  = back_ff;
      sts.gap_fit   = (s_ff >= prev_ff) && (e_ff <= cur_s);
      sts.meet      = (s_ff < cur_e) && (cur_s < e_ff);
      sts.left      = (cur_s < s_ff);
      sts.right     = (e_ff < cur_e);
      sts.sh_more   = cmd.sh_open ? (k_ff > pos_ff) : ((k_ff + ONE) < cnt_ff);
      sts.out_free  = !rv_ff || !rsp_stall;
   end

   assign rsp_valid        = rv_ff;
   assign rsp_status       = rst_ff;
   assign rsp_found_start  = rs_ff;
   assign rsp_found_end    = re_ff;
   assign rsp_found_offset = ro_ff;

   `SRT_ASSERT_IMP(a_cnt_range, clock, reset, 1'b1, cnt_ff <= FULL)
   `SRT_ASSERT_IMP(a_no_grow_full, clock, reset, cmd.cnt_inc, cnt_ff < FULL)
   `SRT_ASSERT_IMP(a_no_shrink_empty, clock, reset, cmd.cnt_dec, cnt_ff != '0)
   `SRT_ASSERT_NXT(a_out_shown, clock, reset, cmd.out_ld, rv_ff)

endmodule

// ===== hdl/sorted_region_table.sv =====
// Lookup walks the entries in order until one contains the query address.
// Insert scans for a gap, then moves later entries up one slot in the RAM.
// Remove visits every entry, moving later entries on a delete or split.
// One word in flight; each moved entry is read and then written one slot over.
// Synchronous reset empties the table (count zero) and drops any pending result;
// no clearing pass.
// ----------------------------------------------------------------------------
// sorted_region_table
// Ordered table of non-overlapping regions with insert, lookup, remove-range.
// ----------------------------------------------------------------------------
module sorted_region_table #(
   parameter int TABLE_DEPTH  = 16,
   parameter int ADDRESS_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [31:0] req_range_start,
   input  logic [31:0] req_range_end,
   input  logic [31:0] req_base_offset,
   input  logic [31:0] req_query_address,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_found_start,
   output logic [31:0] rsp_found_end,
   output logic [31:0] rsp_found_offset
);

   srt_pkg::cmd_type cmd;
   srt_pkg::sts_type sts;

   srt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   srt_dpath #(
      .TABLE_DEPTH  (TABLE_DEPTH),
      .ADDRESS_BITS (ADDRESS_BITS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_operation     (req_operation),
      .req_range_start   (req_range_start),
      .req_range_end     (req_range_end),
      .req_base_offset   (req_base_offset),
      .req_query_address (req_query_address),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_found_start   (rsp_found_start),
      .rsp_found_end     (rsp_found_end),
      .rsp_found_offset  (rsp_found_offset)
   );

endmodule

// ===== dv/sorted_region_table_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_region_table_tb
// Self-checking bench for the sorted region table: directed operations, then
// random insert/lookup/remove traffic mostly on a small address window, all
// checked against a behavioral table copy or fixed expected response words.
// ----------------------------------------------------------------------------
module sorted_region_table_tb;

   localparam int DEPTH      = 16;
   localparam int N_RANDOM   = 900;
   localparam int WDOG_LIMIT = 20000;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] rs;
      logic [31:0] re;
      logic [31:0] off;
      logic [31:0] qa;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] fs;
      logic [31:0] fe;
      logic [31:0] fo;
   } rsp_word_type;

   typedef struct {
      req_word_type req;
      bit           has_exp;
      rsp_word_type exp;
   } dir_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_operation;
   logic [31:0] req_range_start;
   logic [31:0] req_range_end;
   logic [31:0] req_base_offset;
   logic [31:0] req_query_address;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_found_start;
   logic [31:0] rsp_found_end;
   logic [31:0] rsp_found_offset;

   sorted_region_table #(.TABLE_DEPTH(DEPTH), .ADDRESS_BITS(32)) dut (.*);

   logic [31:0] tbl_start [DEPTH+1];
   logic [31:0] tbl_end   [DEPTH+1];
   logic [31:0] tbl_off   [DEPTH+1];
   int          tbl_cnt;

   rsp_word_type pending_rsp[$];
   int           errors;
   int           idle_cycles;
   bit           quiet;
   bit           hold_long;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      errors++;
   endtask

   function automatic void slot_open(input int pos);
      for (int k = tbl_cnt; k > pos; k--) begin
         tbl_start[k] = tbl_start[k-1];
         tbl_end[k]   = tbl_end[k-1];
         tbl_off[k]   = tbl_off[k-1];
      end
      tbl_cnt++;
   endfunction

   function automatic void slot_close(input int pos);
      for (int k = pos; k + 1 < tbl_cnt; k++) begin
         tbl_start[k] = tbl_start[k+1];
         tbl_end[k]   = tbl_end[k+1];
         tbl_off[k]   = tbl_off[k+1];
      end
      tbl_cnt--;
   endfunction

   function automatic logic [1:0] region_insert(input logic [31:0] s, e, off);
      int pos;
      bit fit;
      pos = 0;
      fit = 0;
      if (tbl_cnt == 0 || e <= tbl_start[0]) begin
         fit = 1;
      end else if (s >= tbl_end[tbl_cnt-1]) begin
         fit = 1;
         pos = tbl_cnt;
      end else begin
         for (int i = 1; i < tbl_cnt; i++)
            if (!fit && s >= tbl_end[i-1] && e <= tbl_start[i]) begin
               fit = 1;
               pos = i;
            end
      end
      if (!fit) return srt_pkg::ST_OVERLAP;
      if (tbl_cnt >= DEPTH) return srt_pkg::ST_FULL;
      slot_open(pos);
      tbl_start[pos] = s;
      tbl_end[pos]   = e;
      tbl_off[pos]   = off;
      return srt_pkg::ST_DONE;
   endfunction

   function automatic logic [1:0] region_remove(input logic [31:0] s, e);
      int i;
      logic [31:0] ms, me;
      bit lft, rgt;
      i = 0;
      while (i < tbl_cnt) begin
         ms = tbl_start[i];
         me = tbl_end[i];
         if (!(s < me && ms < e)) begin
            i++;
         end else begin
            lft = ms < s;
            rgt = e < me;
            if (!lft && !rgt) begin
               slot_close(i);
            end else if (lft && rgt) begin
               if (tbl_cnt >= DEPTH) return srt_pkg::ST_FULL;
               slot_open(i + 1);
               tbl_start[i+1] = e;
               tbl_end[i+1]   = me;
               tbl_off[i+1]   = tbl_off[i] + (e - ms);
               tbl_end[i]     = s;
               i += 2;
            end else begin
               if (lft) begin
                  tbl_end[i] = s;
               end else begin
                  tbl_off[i]   = tbl_off[i] + (e - ms);
                  tbl_start[i] = e;
               end
               i++;
            end
         end
      end
      return srt_pkg::ST_DONE;
   endfunction

   function automatic rsp_word_type predict_region_op(input req_word_type r);
      rsp_word_type o;
      o = '0;
      case (r.op)
         srt_pkg::OP_INSERT: o.status = region_insert(r.rs, r.re, r.off);
         srt_pkg::OP_REMOVE: o.status = region_remove(r.rs, r.re);
         srt_pkg::OP_LOOKUP: begin
            o.status = srt_pkg::ST_MISS;
            for (int i = 0; i < tbl_cnt; i++)
               if (o.status == srt_pkg::ST_MISS && tbl_start[i] <= r.qa && r.qa < tbl_end[i])
               begin
                  o.status = srt_pkg::ST_DONE;
                  o.fs = tbl_start[i];
                  o.fe = tbl_end[i];
                  o.fo = tbl_off[i];
               end
         end
         default: o.status = srt_pkg::ST_DONE;
      endcase
      return o;
   endfunction

   function automatic req_word_type mk(input logic [1:0] op,
                                       input logic [31:0] rs, re, off, qa);
      req_word_type r;
      r.op = op; r.rs = rs; r.re = re; r.off = off; r.qa = qa;
      return r;
   endfunction

   function automatic logic [31:0] rand_addr();
      case ($urandom_range(0, 9))
         0:       return $urandom();
         1:       return 32'hFFFF_FFFF - $urandom_range(0, 300);
         default: return $urandom_range(0, 400);
      endcase
   endfunction

   function automatic req_word_type rand_req();
      req_word_type r;
      logic [31:0] a;
      int sel;
      r.off = $urandom();
      r.qa  = rand_addr();
      a     = rand_addr();
      r.rs  = a;
      r.re  = a + $urandom_range(1, 40);
      if ($urandom_range(0, 15) == 0) r.re = rand_addr();
      sel = $urandom_range(0, 99);
      if (sel < 45)      r.op = srt_pkg::OP_INSERT;
      else if (sel < 75) r.op = srt_pkg::OP_LOOKUP;
      else if (sel < 97) r.op = srt_pkg::OP_REMOVE;
      else               r.op = 2'd3;
      if (r.op == srt_pkg::OP_LOOKUP && tbl_cnt > 0 && $urandom_range(0, 1)) begin
         sel  = $urandom_range(0, tbl_cnt - 1);
         r.qa = tbl_start[sel] + $urandom_range(0, 2);
      end
      return r;
   endfunction

   task automatic send_word(input req_word_type r, input bit has_exp,
                            input rsp_word_type exp);
      int gap;
      rsp_word_type pred;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 17);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_operation     <= r.op;
      req_range_start   <= r.rs;
      req_range_end     <= r.re;
      req_base_offset   <= r.off;
      req_query_address <= r.qa;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pred = predict_region_op(r);
      pending_rsp.push_back(has_exp ? exp : pred);
      @(negedge clock);
   endtask

   // receiver stall pattern: random bursts, one long hold-off
   initial begin
      int n;
      rsp_stall = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_long) begin
            rsp_stall <= 1'b1;
            repeat (300) @(negedge clock);
            hold_long = 0;
            rsp_stall <= 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 17);
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      rsp_word_type w;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WDOG_LIMIT) begin
            $display("watchdog expired");
            $display("TB_ERROR");
            $finish;
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_rsp.size() == 0) begin
               report("unexpected word", {30'd0, rsp_status}, 32'd0);
            end else begin
               w = pending_rsp.pop_front();
               if (rsp_status !== w.status)
                  report("status", {30'd0, rsp_status}, {30'd0, w.status});
               if (rsp_found_start !== w.fs) report("found_start", rsp_found_start, w.fs);
               if (rsp_found_end !== w.fe) report("found_end", rsp_found_end, w.fe);
               if (rsp_found_offset !== w.fo) report("found_offset", rsp_found_offset, w.fo);
            end
         end
      end
   end

   initial begin
      dir_row_type rows[$];
      int          n;
      errors = 0; quiet = 0; hold_long = 0; tbl_cnt = 0;
      reset = 1'b1;
      req_valid = 1'b0; req_operation = '0; req_range_start = '0; req_range_end = '0;
      req_base_offset = '0; req_query_address = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      rows.push_back('{mk(srt_pkg::OP_LOOKUP, 0, 0, 0, 0), 1,
                       '{srt_pkg::ST_MISS, 0, 0, 0}});
      rows.push_back('{mk(srt_pkg::OP_REMOVE, 0, 32'hFFFF_FFFF, 0, 0), 1,
                       '{srt_pkg::ST_DONE, 0, 0, 0}});
      rows.push_back('{mk(srt_pkg::OP_INSERT, 100, 200, 32'hFFFF_FFF0, 0), 1,
                       '{srt_pkg::ST_DONE, 0, 0, 0}});
      rows.push_back('{mk(srt_pkg::OP_LOOKUP, 0, 0, 0, 100), 1,
                       '{srt_pkg::ST_DONE, 100, 200, 32'hFFFF_FFF0}});
      rows.push_back('{mk(srt_pkg::OP_LOOKUP, 0, 0, 0, 200), 1,
                       '{srt_pkg::ST_MISS, 0, 0, 0}});
      rows.push_back('{mk(srt_pkg::OP_INSERT, 150, 250, 0, 0), 1,
                       '{srt_pkg::ST_OVERLAP, 0, 0, 0}});
      rows.push_back('{mk(srt_pkg::OP_INSERT, 0, 100, 5, 0), 0, '0});
      rows.push_back('{mk(srt_pkg::OP_INSERT, 32'hFFFF_FF00, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0),
                       0, '0});
      rows.push_back('{mk(srt_pkg::OP_INSERT, 300, 400, 7, 0), 0, '0});
      rows.push_back('{mk(srt_pkg::OP_INSERT, 200, 300, 9, 0), 0, '0});
      rows.push_back('{mk(srt_pkg::OP_INSERT, 500, 500, 1, 0), 0, '0});
      rows.push_back('{mk(srt_pkg::OP_INSERT, 600, 550, 1, 0), 0, '0});
      rows.push_back('{mk(2'd3, 1, 2, 3, 4), 1, '{srt_pkg::ST_DONE, 0, 0, 0}});
      rows.push_back('{mk(srt_pkg::OP_REMOVE, 120, 130, 0, 0), 0, '0});
      rows.push_back('{mk(srt_pkg::OP_LOOKUP, 0, 0, 0, 125), 1,
                       '{srt_pkg::ST_MISS, 0, 0, 0}});
      rows.push_back('{mk(srt_pkg::OP_LOOKUP, 0, 0, 0, 130), 0, '0});
      rows.push_back('{mk(srt_pkg::OP_REMOVE, 50, 110, 0, 0), 0, '0});
      rows.push_back('{mk(srt_pkg::OP_REMOVE, 250, 350, 0, 0), 0, '0});
      rows.push_back('{mk(srt_pkg::OP_REMOVE, 400, 300, 0, 0), 0, '0});
      rows.push_back('{mk(srt_pkg::OP_REMOVE, 200, 400, 0, 0), 0, '0});
      rows.push_back('{mk(srt_pkg::OP_LOOKUP, 0, 0, 0, 32'hFFFF_FFFE), 0, '0});
      rows.push_back('{mk(srt_pkg::OP_LOOKUP, 0, 0, 0, 32'hFFFF_FFFF), 0, '0});
      for (int k = 0; k < 14; k++)
         rows.push_back('{mk(srt_pkg::OP_INSERT, 1000 + 10*k, 1005 + 10*k, k, 0), 0, '0});
      rows.push_back('{mk(srt_pkg::OP_INSERT, 5000, 5001, 0, 0), 1,
                       '{srt_pkg::ST_FULL, 0, 0, 0}});
      rows.push_back('{mk(srt_pkg::OP_REMOVE, 1001, 1002, 0, 0), 1,
                       '{srt_pkg::ST_FULL, 0, 0, 0}});
      rows.push_back('{mk(srt_pkg::OP_REMOVE, 0, 32'hFFFF_FFFF, 0, 0), 1,
                       '{srt_pkg::ST_DONE, 0, 0, 0}});

      foreach (rows[i]) send_word(rows[i].req, rows[i].has_exp, rows[i].exp);

      n = 0;
      while (n < N_RANDOM) begin
         if (n == 200) hold_long = 1;
         if (n == N_RANDOM - 150) quiet = 1;
         if ($urandom_range(0, 60) == 0) begin
            send_word(mk(srt_pkg::OP_REMOVE, 0, 32'hFFFF_FFFF, 0, 0), 1'b0, '0);
         end else begin
            send_word(rand_req(), 1'b0, '0);
         end
         n++;
      end
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (2 * DEPTH * 4 + 20) @(negedge clock);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule

// ===== sorted_region_table.f =====
+incdir+hdl
hdl/srt_pkg.sv
hdl/srt_ram.sv
hdl/srt_ctrl.sv
hdl/srt_dpath.sv
hdl/sorted_region_table.sv
dv/sorted_region_table_tb.sv
